// ===== hw/rtl/maes_pkg.sv =====
// Mini-AES package: S-box tables, GF(2^4) column mix, nibble swap and
// the nibble key schedule used by the cipher core.
// No dependencies.
package maes_pkg;

   localparam int unsigned BLOCK_W  = 16;
   localparam int unsigned NIBBLE_W = 4;

   // Operation selector carried in tuser
   localparam logic OP_ENCRYPT = 1'b0;
   localparam logic OP_DECRYPT = 1'b1;

   // Round constants of the key schedule
   localparam logic [NIBBLE_W-1:0] RCON_ROUND1 = 4'h1;
   localparam logic [NIBBLE_W-1:0] RCON_ROUND2 = 4'h2;

   // Reduction of x^4 inside GF(2^4) modulo x^4+x+1
   localparam logic [NIBBLE_W-1:0] GF_REDUCE = 4'h3;

   localparam logic [NIBBLE_W-1:0] SBOX_ROM [16] = '{
      4'hE, 4'h4, 4'hD, 4'h1, 4'h2, 4'hF, 4'hB, 4'h8,
      4'h3, 4'hA, 4'h6, 4'hC, 4'h5, 4'h9, 4'h0, 4'h7
   };

   localparam logic [NIBBLE_W-1:0] INV_SBOX_ROM [16] = '{
      4'hE, 4'h3, 4'h4, 4'h8, 4'h1, 4'hC, 4'hA, 4'hF,
      4'h7, 4'hD, 4'h9, 4'h6, 4'hB, 4'h2, 4'h0, 4'h5
   };

   // Key material held after a key write: the three round keys plus
   // the column-mixed middle key used on the decrypt path.
   typedef struct packed {
      logic [BLOCK_W-1:0] k0;
      logic [BLOCK_W-1:0] k1;
      logic [BLOCK_W-1:0] k2;
      logic [BLOCK_W-1:0] k1_mixed;
   } key_set_type;

   // Substitute all four nibbles through the forward or inverse box
   function automatic logic [BLOCK_W-1:0] sub_nibbles(input logic [BLOCK_W-1:0] b,
                                                      input logic inverse);
      logic [BLOCK_W-1:0] r;
      r = '0;
      for (int i = 0; i < 4; i++) begin
         r[i*NIBBLE_W +: NIBBLE_W] = inverse ? INV_SBOX_ROM[b[i*NIBBLE_W +: NIBBLE_W]]
                                             : SBOX_ROM[b[i*NIBBLE_W +: NIBBLE_W]];
      end
      return r;
   endfunction

   // Exchange nibble 1 (bits 11:8) and nibble 3 (bits 3:0)
   function automatic logic [BLOCK_W-1:0] swap13(input logic [BLOCK_W-1:0] b);
      return {b[15:12], b[3:0], b[7:4], b[11:8]};
   endfunction

   function automatic logic [NIBBLE_W-1:0] gf_x2(input logic [NIBBLE_W-1:0] a);
      return {a[2:0], 1'b0} ^ (a[3] ? GF_REDUCE : 4'h0);
   endfunction

   function automatic logic [NIBBLE_W-1:0] gf_x3(input logic [NIBBLE_W-1:0] a);
      return gf_x2(a) ^ a;
   endfunction

   // Column mix with matrix [[3,2],[2,3]] on columns (n0,n1) and (n2,n3)
   function automatic logic [BLOCK_W-1:0] mix(input logic [BLOCK_W-1:0] b);
      logic [NIBBLE_W-1:0] p0;
      logic [NIBBLE_W-1:0] p1;
      logic [NIBBLE_W-1:0] p2;
      logic [NIBBLE_W-1:0] p3;
      p0 = b[15:12];
      p1 = b[11:8];
      p2 = b[7:4];
      p3 = b[3:0];
      return {gf_x3(p0) ^ gf_x2(p1), gf_x2(p0) ^ gf_x3(p1),
              gf_x3(p2) ^ gf_x2(p3), gf_x2(p2) ^ gf_x3(p3)};
   endfunction

   function automatic logic [BLOCK_W-1:0] next_round_key(input logic [BLOCK_W-1:0] k,
                                                         input logic [NIBBLE_W-1:0] rc);
      logic [NIBBLE_W-1:0] a;
      logic [NIBBLE_W-1:0] b;
      logic [NIBBLE_W-1:0] c;
      logic [NIBBLE_W-1:0] d;
      a = k[15:12] ^ SBOX_ROM[k[3:0]] ^ rc;
      b = k[11:8] ^ a;
      c = k[7:4] ^ b;
      d = k[3:0] ^ c;
      return {a, b, c, d};
   endfunction

   // Expand a master key into the full key set
   function automatic key_set_type expand_key(input logic [BLOCK_W-1:0] k);
      key_set_type ks;
      ks.k0       = k;
      ks.k1       = next_round_key(k, RCON_ROUND1);
      ks.k2       = next_round_key(ks.k1, RCON_ROUND2);
      ks.k1_mixed = mix(ks.k1);
      return ks;
   endfunction

endpackage

// ===== hw/rtl/mini_aes_cipher_core.sv =====
// Mini-AES 16-bit block cipher core, three-stage pipeline.
// Depends on maes_pkg for the S-boxes, column mix and key schedule.
//
// Usage:
//   csr_*  : key write channel; csr_data is the 16-bit master key. The
//            round keys are expanded when the word is taken, so a block
//            may follow in the very next cycle. csr_ready is always high.
//            Write the key only while no block is in flight.
//   req_*  : block in. tdata = data_block[15:0]; tuser = op
//            (0 encrypt, 1 decrypt).
//   rsp_*  : block out. tdata = result_block[15:0].
// A block goes through stage registers s1, s2, s3 to rsp_tvalid; one block
// is taken every cycle while req_tready is high. Each stage is a round half:
// key add, nibble swap and S-box lookup, then column mix with key add, then
// the final swap, S-box and key add; the last stage is the output register.
// When the receiver stalls, each stage holds its word and bubbles close up,
// so req_tready drops only once all three stages are full.
// Reset clears all stage valid bits and sets the master key to zero.
module mini_aes_cipher_core (
   input  logic                          clock,
   input  logic                          reset,
   // key write
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [maes_pkg::BLOCK_W-1:0]  csr_data,    // master_key[15:0]
   // block in
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [maes_pkg::BLOCK_W-1:0]  req_tdata,   // data_block[15:0]
   input  logic                          req_tuser,   // op
   // block out
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [maes_pkg::BLOCK_W-1:0]  rsp_tdata    // result_block[15:0]
);
   import maes_pkg::*;

   key_set_type        key_ff, key_in;

   logic               s1_valid_ff, s2_valid_ff, s3_valid_ff;
   logic               s1_op_ff, s2_op_ff;
   logic [BLOCK_W-1:0] s1_data_ff, s2_data_ff, s3_data_ff;
   logic [BLOCK_W-1:0] s1_data_in, s2_data_in, s3_data_in;
   logic               s1_ready, s2_ready, s3_ready;

   assign csr_ready = 1'b1;

   // Expand the key once on write
   assign key_in = (csr_valid && csr_ready) ? expand_key(csr_data) : key_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= expand_key('0);
      end else begin
         key_ff <= key_in;
      end
   end

   // Stage handshake: a stage advances when empty or when the next one moves
   assign s3_ready   = !s3_valid_ff || rsp_tready;
   assign s2_ready   = !s2_valid_ff || s3_ready;
   assign s1_ready   = !s1_valid_ff || s2_ready;
   assign req_tready = s1_ready;

   // Stage 1: first key add, swap, substitution
   assign s1_data_in = sub_nibbles(swap13(req_tdata ^
                          ((req_tuser == OP_DECRYPT) ? key_ff.k2 : key_ff.k0)),
                          req_tuser == OP_DECRYPT);

   // Stage 2: column mix and middle key; mix is linear so decrypt adds mix(k1)
   assign s2_data_in = mix(s1_data_ff) ^
                       ((s1_op_ff == OP_DECRYPT) ? key_ff.k1_mixed : key_ff.k1);

   // Stage 3: swap, substitution, last key add
   assign s3_data_in = sub_nibbles(swap13(s2_data_ff), s2_op_ff == OP_DECRYPT) ^
                       ((s2_op_ff == OP_DECRYPT) ? key_ff.k0 : key_ff.k2);

   // Valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) begin
            s1_valid_ff <= req_tvalid;
         end
         if (s2_ready) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (s3_ready) begin
            s3_valid_ff <= s2_valid_ff;
         end
      end
   end

   // Payload; hold while the stage is stalled
   always_ff @(posedge clock) begin
      if (s1_ready) begin
         s1_data_ff <= s1_data_in;
         s1_op_ff   <= req_tuser;
      end
      if (s2_ready) begin
         s2_data_ff <= s2_data_in;
         s2_op_ff   <= s1_op_ff;
      end
      if (s3_ready) begin
         s3_data_ff <= s3_data_in;
      end
   end

   assign rsp_tvalid = s3_valid_ff;
   assign rsp_tdata  = s3_data_ff;

endmodule

// ===== hw/rtl/maes_checker.sv =====
// Port-level checks for the Mini-AES cipher core, bound to its top level.
// Depends on maes_pkg for the block width.
module maes_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_tvalid,
   input logic                          req_tready,
   input logic                          rsp_tvalid,
   input logic                          rsp_tready,
   input logic [maes_pkg::BLOCK_W-1:0]  rsp_tdata
);

   // Reset empties the pipeline
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("rsp_tvalid high right after reset");

   // A stalled output word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled output word changed or dropped");

   // Input back-pressure only comes from a stalled output
   a_ready_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("req_tready low without an output stall");

   // A word taken with the output draining reaches the output through stages 2 and 3
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) ##1 rsp_tready ##1 rsp_tready |=> rsp_tvalid)
      else $error("accepted word did not reach the output in time");

endmodule

bind mini_aes_cipher_core maes_checker u_maes_checker (.*);
